@@ rtl/core/owbm_pkg.sv @@
// Shared types, constants and helpers for the 1-Wire bus master core.
// No dependencies.
package owbm_pkg;

  localparam int READ_BITS  = 16;
  localparam int WORD_W     = 16;
  localparam int TICK_W     = 16;
  localparam int BIT_IDX_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int WORD_SHIFT = WORD_W - READ_BITS;

  localparam logic [BIT_IDX_W-1:0] BYTE_BITS = BIT_IDX_W'(8);
  localparam logic [BIT_IDX_W-1:0] WORD_BITS = BIT_IDX_W'(READ_BITS);

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TICK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT           = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PULLUP         = 3'd7;

  typedef struct packed {
    logic [TICK_W-1:0] reset_low_ticks;
    logic [TICK_W-1:0] reset_release_ticks;
    logic [TICK_W-1:0] presence_sample_tick;
    logic [TICK_W-1:0] zero_low_ticks;
    logic [TICK_W-1:0] short_low_ticks;
    logic [TICK_W-1:0] read_sample_tick;
    logic [TICK_W-1:0] slot_ticks;
    logic [TICK_W-1:0] pullup_ticks;
  } owbm_cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] write_byte;
    logic       strong_pullup;
    logic       bus_level;
  } owbm_item_t;

  typedef struct packed {
    logic                     drive_low;
    logic                     drive_high;
    logic                     busy_res;
    logic                     done_res;
    logic                     presence;
    logic signed [WORD_W-1:0] read_word;
  } owbm_res_t;

  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

@@ rtl/core/owbm_if.sv @@
// Valid/ready channel interfaces for the 1-Wire bus master core.
// Depends on owbm_pkg.
interface owbm_in_if import owbm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] write_byte;
  logic       strong_pullup;
  logic       bus_level;

  modport source (output valid, command, write_byte, strong_pullup, bus_level, input ready);
  modport sink   (input valid, command, write_byte, strong_pullup, bus_level, output ready);
endinterface

interface owbm_out_if import owbm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     drive_low;
  logic                     drive_high;
  logic                     busy_res;
  logic                     done_res;
  logic                     presence;
  logic signed [WORD_W-1:0] read_word;

  modport source (output valid, drive_low, drive_high, busy_res, done_res, presence,
                  read_word, input ready);
  modport sink   (input valid, drive_low, drive_high, busy_res, done_res, presence,
                  read_word, output ready);
endinterface

@@ rtl/core/owbm_cfg.sv @@
// Timing register bank for the 1-Wire bus master core.
// Depends on owbm_pkg.
module owbm_cfg import owbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata,
  output owbm_cfg_t            cfg
);

  owbm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks      <= TICK_W'(480);
      cfg_r.reset_release_ticks  <= TICK_W'(480);
      cfg_r.presence_sample_tick <= TICK_W'(70);
      cfg_r.zero_low_ticks       <= TICK_W'(60);
      cfg_r.short_low_ticks      <= TICK_W'(5);
      cfg_r.read_sample_tick     <= TICK_W'(10);
      cfg_r.slot_ticks           <= TICK_W'(61);
      cfg_r.pullup_ticks         <= TICK_W'(10000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:     cfg_r.reset_low_ticks      <= cfg_wdata;
        REG_RESET_RELEASE: cfg_r.reset_release_ticks  <= cfg_wdata;
        REG_PRESENCE_TICK: cfg_r.presence_sample_tick <= cfg_wdata;
        REG_ZERO_LOW:      cfg_r.zero_low_ticks       <= cfg_wdata;
        REG_SHORT_LOW:     cfg_r.short_low_ticks      <= cfg_wdata;
        REG_READ_SAMPLE:   cfg_r.read_sample_tick     <= cfg_wdata;
        REG_SLOT:          cfg_r.slot_ticks           <= cfg_wdata;
        REG_PULLUP:        cfg_r.pullup_ticks         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/owbm_ctrl.sv @@
// Bus sequencer: phase, tick counter and shift register, one tick per transaction.
// Depends on owbm_pkg.
module owbm_ctrl import owbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick_en,
  input  owbm_item_t item,
  input  owbm_cfg_t  cfg,
  output owbm_res_t  res_nxt
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_RST_LOW = 3'd1;
  localparam logic [2:0] PH_RST_REL = 3'd2;
  localparam logic [2:0] PH_WRITE   = 3'd3;
  localparam logic [2:0] PH_PULLUP  = 3'd4;
  localparam logic [2:0] PH_READ    = 3'd5;

  logic [2:0]           phase_r, phase_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [WORD_W-1:0]    shift_r, shift_nxt;
  logic                 pullup_r, pullup_nxt;
  logic                 presence_r, presence_nxt;
  logic [WORD_W-1:0]    word_r, word_nxt;
  logic [TICK_W:0]      tick_inc;
  logic [TICK_W-1:0]    low_ticks;

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    pullup_nxt   = pullup_r;
    presence_nxt = presence_r;
    word_nxt     = word_r;
    res_nxt      = '0;
    low_ticks    = '0;

    if (phase_r == PH_IDLE) begin
      case (item.command)
        CMD_RESET: begin
          phase_nxt    = PH_RST_LOW;
          tick_nxt     = '0;
          presence_nxt = 1'b0;
        end
        CMD_WRITE: begin
          phase_nxt   = PH_WRITE;
          tick_nxt    = '0;
          bit_idx_nxt = '0;
          shift_nxt   = WORD_W'(item.write_byte);
          pullup_nxt  = item.strong_pullup;
        end
        CMD_READ: begin
          phase_nxt   = PH_READ;
          tick_nxt    = '0;
          bit_idx_nxt = '0;
          shift_nxt   = '0;
        end
        default: ;
      endcase
    end

    tick_inc = {1'b0, tick_nxt} + (TICK_W+1)'(1);

    unique case (phase_nxt)
      PH_IDLE: ;
      PH_RST_LOW: begin
        res_nxt.busy_res  = 1'b1;
        res_nxt.drive_low = 1'b1;
        if (tick_inc >= {1'b0, at_least_one(cfg.reset_low_ticks)}) begin
          phase_nxt = PH_RST_REL;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_RST_REL: begin
        res_nxt.busy_res = 1'b1;
        if (tick_inc == {1'b0, cfg.presence_sample_tick} && !item.bus_level)
          presence_nxt = 1'b1;
        if (tick_inc >= {1'b0, at_least_one(cfg.reset_release_ticks)}) begin
          res_nxt.done_res = 1'b1;
          phase_nxt        = PH_IDLE;
          tick_nxt         = '0;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_WRITE: begin
        res_nxt.busy_res  = 1'b1;
        low_ticks         = shift_nxt[0] ? cfg.short_low_ticks : cfg.zero_low_ticks;
        res_nxt.drive_low = (tick_nxt < low_ticks);
        if (tick_inc >= {1'b0, at_least_one(cfg.slot_ticks)}) begin
          tick_nxt    = '0;
          shift_nxt   = shift_nxt >> 1;
          bit_idx_nxt = bit_idx_nxt + BIT_IDX_W'(1);
          if (bit_idx_nxt >= BYTE_BITS) begin
            if (pullup_nxt) begin
              phase_nxt = PH_PULLUP;
            end else begin
              res_nxt.done_res = 1'b1;
              phase_nxt        = PH_IDLE;
            end
          end
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_PULLUP: begin
        res_nxt.busy_res   = 1'b1;
        res_nxt.drive_high = 1'b1;
        if (tick_inc >= {1'b0, at_least_one(cfg.pullup_ticks)}) begin
          res_nxt.done_res = 1'b1;
          phase_nxt        = PH_IDLE;
          tick_nxt         = '0;
          pullup_nxt       = 1'b0;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_READ: begin
        res_nxt.busy_res = 1'b1;
        if (tick_nxt == '0)
          shift_nxt = shift_nxt >> 1;
        res_nxt.drive_low = (tick_nxt < cfg.short_low_ticks);
        if (tick_nxt == cfg.read_sample_tick && item.bus_level)
          shift_nxt[WORD_W-1] = 1'b1;
        if (tick_inc >= {1'b0, at_least_one(cfg.slot_ticks)}) begin
          tick_nxt    = '0;
          bit_idx_nxt = bit_idx_nxt + BIT_IDX_W'(1);
          if (bit_idx_nxt >= WORD_BITS) begin
            word_nxt         = shift_nxt >> WORD_SHIFT;
            res_nxt.done_res = 1'b1;
            phase_nxt        = PH_IDLE;
          end
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    res_nxt.presence  = presence_nxt;
    res_nxt.read_word = $signed(word_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      bit_idx_r  <= '0;
      shift_r    <= '0;
      pullup_r   <= 1'b0;
      presence_r <= 1'b0;
      word_r     <= '0;
    end else if (tick_en) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_idx_r  <= bit_idx_nxt;
      shift_r    <= shift_nxt;
      pullup_r   <= pullup_nxt;
      presence_r <= presence_nxt;
      word_r     <= word_nxt;
    end
  end

endmodule

@@ rtl/core/one_wire_bus_master_core.sv @@
// 1-Wire bus master core: one tick per input transaction, one result per tick.
// Timing registers, sequencer and a registered result stage.
// Depends on owbm_pkg, owbm_if, owbm_cfg and owbm_ctrl.

// Each input transaction is one bus tick and yields exactly one result transaction,
// presented from the output register on the clock after acceptance. One tick is
// accepted every cycle unless the output stalls: the output register lets a new
// tick in whenever its held result is being taken or it is empty. Commands are
// taken only on ticks while no command is in progress, else ignored. Slot timings
// are counted in ticks from the eight cfg registers, which the user must ensure
// are written only while no command is running; the block does not enforce it.

module one_wire_bus_master_core import owbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  owbm_in_if.sink              in_if,
  owbm_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  owbm_cfg_t  cfg;
  owbm_item_t item;
  owbm_res_t  res_nxt;
  owbm_res_t  res_r;
  logic       out_valid_r;
  logic       in_fire;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  assign item.command       = in_if.command;
  assign item.write_byte    = in_if.write_byte;
  assign item.strong_pullup = in_if.strong_pullup;
  assign item.bus_level     = in_if.bus_level;

  owbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owbm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (in_fire),
    .item    (item),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      out_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.drive_low  = res_r.drive_low;
  assign out_if.drive_high = res_r.drive_high;
  assign out_if.busy_res   = res_r.busy_res;
  assign out_if.done_res   = res_r.done_res;
  assign out_if.presence   = res_r.presence;
  assign out_if.read_word  = res_r.read_word;

  a_no_contention: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.drive_low && res_r.drive_high))
    else $error("bus driven low and high on the same tick");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> res_r.busy_res)
    else $error("done reported outside a command");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(res_r))
    else $error("stalled result changed");

endmodule
